FILE: hdl/radix_string_to_integer_assert.svh
// Assertion macros shared by the radix string parser.
// Expects clk and rst_n in scope where expanded.
`ifndef RADIX_STRING_TO_INTEGER_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSTI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSTI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rsti_pkg.sv
// Shared types, codes and character helpers for the radix string parser.
// No dependencies.
`timescale 1ns / 1ps

package rsti_pkg;

  localparam int ACC_W = 64;
  localparam int RAD_W = 7;
  localparam int CHAR_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_MODE = 2'd1;

  localparam logic signed [RAD_W-1:0] RADIX_MODE_RST = 7'sd10;
  localparam logic signed [RAD_W-1:0] RADIX_MAX      = 7'sd36;
  localparam logic signed [RAD_W-1:0] RADIX_MIN      = -7'sd36;
  localparam logic signed [RAD_W-1:0] RADIX_ONE      = 7'sd1;
  localparam logic signed [RAD_W-1:0] RADIX_NEG_ONE  = -7'sd1;

  localparam logic [RAD_W-1:0] RAD_2  = 7'd2;
  localparam logic [RAD_W-1:0] RAD_8  = 7'd8;
  localparam logic [RAD_W-1:0] RAD_10 = 7'd10;
  localparam logic [RAD_W-1:0] RAD_16 = 7'd16;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UP_O  = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_LO_O  = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_UP_D  = 8'h44;
  localparam logic [CHAR_W-1:0] CH_LO_D  = 8'h64;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] NO_DIGIT = 8'hFF;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_AFTER_SIGN,
    PH_ZERO_HELD,
    PH_DIGITS,
    PH_TRAIL,
    PH_DONE,
    PH_INVALID
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] magnitude;
    logic             is_negative;
    status_t          status;
  } out_item_t;

  typedef struct packed {
    logic signed [RAD_W-1:0] radix_mode;
    logic                    strict_mode;
  } cfg_t;

  // Digit value 0..35, NO_DIGIT for anything else.
  function automatic logic [CHAR_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
    else if (c >= CH_UP_A && c <= CH_UP_Z) v = c - CH_UP_A + 8'd10;
    else if (c >= CH_LO_A && c <= CH_LO_Z) v = c - CH_LO_A + 8'd10;
    return v;
  endfunction

  function automatic logic is_lead_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_trail_space(input logic [CHAR_W-1:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

endpackage

FILE: hdl/rsti_mac.sv
// Multiply-accumulate of one digit into the magnitude, with overflow flag.
// Depends on rsti_pkg.
`timescale 1ns / 1ps

module rsti_mac (
  input  logic [rsti_pkg::ACC_W-1:0] acc,
  input  logic [rsti_pkg::RAD_W-1:0] radix,
  input  logic [5:0]                 digit,
  output logic [rsti_pkg::ACC_W-1:0] acc_out,
  output logic                       ovf
);
  import rsti_pkg::*;

  logic [ACC_W+RAD_W-1:0] prod;
  logic [ACC_W+RAD_W:0]   sum;

  always_comb begin
    prod    = {{RAD_W{1'b0}}, acc} * {{ACC_W{1'b0}}, radix};
    sum     = {1'b0, prod} + (ACC_W + RAD_W + 1)'(digit);
    ovf     = |sum[ACC_W+RAD_W:ACC_W];
    // saturate on overflow
    acc_out = ovf ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  end

endmodule

FILE: hdl/rsti_parse.sv
// Parse state and per-character next-state logic; forms the result item.
// Depends on rsti_pkg and rsti_mac.
`timescale 1ns / 1ps

module rsti_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  rsti_pkg::in_item_t  item,
  input  rsti_pkg::cfg_t      cfg,
  output rsti_pkg::out_item_t result
);
  import rsti_pkg::*;

  phase_t             phase_r, phase_nxt, phase_step;
  logic [ACC_W-1:0]   acc_r, acc_nxt, acc_step;
  logic [RAD_W-1:0]   rad_r, rad_nxt, rad_step;
  logic               sign_r, sign_nxt, sign_step;
  logic               pend_r, pend_nxt, pend_step;
  logic               ovf_r, ovf_nxt, ovf_step;
  logic               stop_r, stop_nxt, stop_step;

  logic [CHAR_W-1:0]  c;
  logic               last;
  logic signed [RAD_W-1:0] r;
  logic [RAD_W-1:0]   r_abs, det, new_rad, rad_use;
  logic               letter, skip, bad_rad, lead_sp, trail_sp;
  logic               is_us, is_zero;
  logic [CHAR_W-1:0]  dval;
  logic               ds_en, ds_digit, ds_pend, ds_trail, ds_stop, ds_us_stop;
  logic [ACC_W-1:0]   mac_acc;
  logic               mac_ovf;

  // Character and radix decode
  always_comb begin
    c        = item.char_code;
    last     = item.last_char;
    r        = cfg.radix_mode;
    r_abs    = r[RAD_W-1] ? RAD_W'(-r) : RAD_W'(r);
    bad_rad  = (r == RADIX_ONE) || (r == RADIX_NEG_ONE) || (r > RADIX_MAX) || (r < RADIX_MIN);
    lead_sp  = is_lead_space(c);
    trail_sp = is_trail_space(c);
    is_us    = (c == CH_UNDER);
    is_zero  = (c == CH_ZERO);
    dval     = digit_val(c);

    letter = 1'b1;
    if (c == CH_UP_B || c == CH_LO_B) det = RAD_2;
    else if (c == CH_UP_O || c == CH_LO_O) det = RAD_8;
    else if (c == CH_UP_D || c == CH_LO_D) det = RAD_10;
    else if (c == CH_UP_X || c == CH_LO_X) det = RAD_16;
    else begin
      det    = RAD_8;
      letter = 1'b0;
    end

    if (phase_r == PH_ZERO_HELD) begin
      skip    = r[RAD_W-1] || (r == '0) || (RAD_W'(r) == det);
      new_rad = (r[RAD_W-1] || r == '0) ? det : RAD_W'(r);
    end else begin
      skip    = 1'b0;
      new_rad = r[RAD_W-1] ? r_abs : ((r == '0) ? RAD_10 : RAD_W'(r));
    end
    rad_use = (phase_r == PH_DIGITS) ? rad_r : new_rad;

    // Which phases run a digit step on this character. A replayed '0' prefix
    // leaves the magnitude at zero, so only the current character matters.
    unique case (phase_r)
      PH_LEAD:       ds_en = !bad_rad && !lead_sp && !is_us && c != CH_MINUS &&
                             c != CH_PLUS && !is_zero;
      PH_AFTER_SIGN: ds_en = !is_zero;
      PH_ZERO_HELD:  ds_en = !(letter && skip);
      PH_DIGITS:     ds_en = 1'b1;
      default:       ds_en = 1'b0;
    endcase

    ds_us_stop = pend_r && is_us;
    ds_digit   = !ds_us_stop && (dval < {1'b0, rad_use});
    ds_pend    = !ds_us_stop && !ds_digit && is_us && !last;
    ds_trail   = !ds_us_stop && !ds_digit && !is_us && trail_sp;
    ds_stop    = ds_us_stop || (!ds_digit && is_us && last) ||
                 (!ds_digit && !is_us && !trail_sp);
  end

  rsti_mac u_mac (
    .acc     (acc_r),
    .radix   (rad_use),
    .digit   (dval[5:0]),
    .acc_out (mac_acc),
    .ovf     (mac_ovf)
  );

  // Phase transition
  always_comb begin
    phase_step = phase_r;
    unique case (phase_r)
      PH_LEAD: begin
        if (bad_rad) phase_step = PH_INVALID;
        else if (lead_sp) phase_step = PH_LEAD;
        else if (is_us) phase_step = cfg.strict_mode ? PH_INVALID : PH_DONE;
        else if (c == CH_MINUS || c == CH_PLUS) phase_step = PH_AFTER_SIGN;
        else if (is_zero) phase_step = PH_ZERO_HELD;
        else phase_step = ds_stop ? PH_DONE : (ds_trail ? PH_TRAIL : PH_DIGITS);
      end
      PH_AFTER_SIGN: begin
        if (is_zero) phase_step = PH_ZERO_HELD;
        else phase_step = ds_stop ? PH_DONE : (ds_trail ? PH_TRAIL : PH_DIGITS);
      end
      PH_ZERO_HELD: begin
        if (ds_en) phase_step = ds_stop ? PH_DONE : (ds_trail ? PH_TRAIL : PH_DIGITS);
        else phase_step = PH_DIGITS;
      end
      PH_DIGITS: phase_step = ds_stop ? PH_DONE : (ds_trail ? PH_TRAIL : PH_DIGITS);
      PH_TRAIL:  phase_step = trail_sp ? PH_TRAIL : PH_DONE;
      default:   phase_step = phase_r;
    endcase
    phase_nxt = phase_r;
    if (step_en) phase_nxt = last ? PH_LEAD : phase_step;
  end

  // Datapath state
  always_comb begin
    sign_step = sign_r || (phase_r == PH_LEAD && !bad_rad && !lead_sp && c == CH_MINUS);
    rad_step  = ((phase_r == PH_LEAD && ds_en) || (phase_r == PH_AFTER_SIGN && !is_zero) ||
                 phase_r == PH_ZERO_HELD) ? new_rad : rad_r;
    pend_step = ds_en ? ds_pend : pend_r;
    stop_step = stop_r || (ds_en && ds_stop) || (phase_r == PH_TRAIL && !trail_sp);
    acc_step  = acc_r;
    ovf_step  = ovf_r;
    if (ds_en && ds_digit && !ovf_r) begin
      acc_step = mac_acc;
      ovf_step = mac_ovf;
    end

    sign_nxt = sign_r;
    rad_nxt  = rad_r;
    pend_nxt = pend_r;
    stop_nxt = stop_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    if (step_en) begin
      // clear after the final character of a string
      sign_nxt = last ? 1'b0 : sign_step;
      rad_nxt  = last ? '0 : rad_step;
      pend_nxt = last ? 1'b0 : pend_step;
      stop_nxt = last ? 1'b0 : stop_step;
      acc_nxt  = last ? '0 : acc_step;
      ovf_nxt  = last ? 1'b0 : ovf_step;
    end
  end

  // Result of the string, meaningful when the current character is the last
  always_comb begin
    if (phase_step == PH_INVALID || (stop_step && cfg.strict_mode)) begin
      result.magnitude   = '0;
      result.is_negative = 1'b0;
      result.status      = ST_INVALID;
    end else begin
      result.magnitude   = acc_step;
      result.is_negative = sign_step;
      result.status      = ovf_step ? ST_OVERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      sign_r  <= 1'b0;
      rad_r   <= '0;
      pend_r  <= 1'b0;
      stop_r  <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sign_r  <= sign_nxt;
      rad_r   <= rad_nxt;
      pend_r  <= pend_nxt;
      stop_r  <= stop_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

FILE: hdl/radix_string_to_integer.sv
// Flow: an accepted item waits in the input register and is parsed from there; a last
//   item's result goes into the result register and stays until taken. A last item
//   waits while an untaken result is held, so it is parsed when that result goes.
// Throughput: one item per cycle, but a last item waits while an untaken result is held.
// Reset (rst_n low, synchronous): parser back to leading-whitespace, both stages
//   empty, radix_mode 10, strict_mode 0.
`timescale 1ns / 1ps
`include "radix_string_to_integer_assert.svh"

// Top level: input register, config registers, result register around rsti_parse.
// Depends on rsti_pkg, rsti_parse, rsti_mac.
module radix_string_to_integer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rsti_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rsti_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rsti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsti_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rsti_pkg::*;

  // Input register: holds the next character to parse.
  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_r;
  // Result register: holds one finished string result.
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_r;
  out_item_t result;
  // Configuration registers.
  cfg_t      cfg_r, cfg_nxt;

  logic      advance;
  logic      adv_last;

  // A non-last character always advances; the last one needs room in the
  // result register (free now, or being drained this cycle).
  assign advance  = in_vld_r && (!in_r.last_char || !out_vld_r || out_ready);
  assign adv_last = advance && in_r.last_char;
  assign in_ready = !in_vld_r || advance;

  assign in_vld_nxt  = (in_valid && in_ready) || (in_vld_r && !advance);
  assign out_vld_nxt = adv_last || (out_vld_r && !out_ready);

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX_MODE:  cfg_nxt.radix_mode  = RAD_W'(signed'(cfg_data));
        REG_STRICT_MODE: cfg_nxt.strict_mode = cfg_data[0];
        default:         cfg_nxt = cfg_r;  // drop writes to unmapped indexes
      endcase
    end
  end

  rsti_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cfg_r     <= '{radix_mode: RADIX_MODE_RST, strict_mode: 1'b0};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      cfg_r     <= cfg_nxt;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (adv_last) out_r <= result;
  end

  `RSTI_ASSERT_NEXT(a_last_loads_out, adv_last, out_vld_r, "last item did not load result")
  `RSTI_ASSERT_NOW(a_rise_needs_last, $rose(out_vld_r), $past(adv_last),
                   "result appeared without a last item")
  `RSTI_ASSERT_NOW(a_invalid_zero, out_vld_r && out_r.status == ST_INVALID,
                   out_r.magnitude == '0 && !out_r.is_negative,
                   "invalid result carries a value")
  `RSTI_ASSERT_NOW(a_ovf_saturated, out_vld_r && out_r.status == ST_OVERFLOW,
                   out_r.magnitude == {ACC_W{1'b1}}, "overflow result not saturated")

endmodule

FILE: bench/radix_parse_checker.sv
// Checker for radix_string_to_integer: predicts the parse result of each numeral
// from the accepted bytes and register writes, and compares the results in order.
// Depends on rsti_pkg.
`timescale 1ns / 1ps

module radix_parse_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rsti_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rsti_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rsti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsti_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              bad_cnt,
  output int                              checked_cnt,
  output int                              pending
);
  import rsti_pkg::*;

  localparam logic [ACC_W-1:0] ACC_ALL = '1;
  localparam int SHOW_MAX = 10;

  // register copies
  logic signed [RAD_W-1:0] radix_sel;
  logic                    strict;

  // per-string parse state
  logic [ACC_W-1:0] acc;
  bit               neg_seen;
  phase_t           stage;
  int               work_radix;
  bit               uscore_pend;
  bit               ovf;
  logic [7:0]       zero_char;
  bit               cut_short;

  out_item_t expected_q[$];
  int        shown;

  function automatic void clear_string();
    acc = '0;
    neg_seen = 1'b0;
    stage = PH_LEAD;
    work_radix = 0;
    uscore_pend = 1'b0;
    ovf = 1'b0;
    zero_char = '0;
    cut_short = 1'b0;
  endfunction

  function automatic int char_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
    return int'(NO_DIGIT);
  endfunction

  function automatic bit trail_ws(logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic void stop_parse();
    cut_short = 1'b1;
    stage = PH_DONE;
  endfunction

  function automatic void take_digit(logic [7:0] c, bit last);
    int d;
    logic [ACC_W-1:0] lim;
    if (uscore_pend) begin
      uscore_pend = 1'b0;
      if (c == CH_UNDER) begin
        stop_parse();
        return;
      end
    end
    d = char_value(c);
    if (d < work_radix) begin
      if (!ovf) begin
        lim = (ACC_ALL - ACC_W'(d)) / ACC_W'(work_radix);
        if (acc > lim) begin
          ovf = 1'b1;
          acc = ACC_ALL;
        end else begin
          acc = acc * ACC_W'(work_radix) + ACC_W'(d);
        end
      end
      return;
    end
    if (c == CH_UNDER) begin
      if (last) stop_parse();
      else uscore_pend = 1'b1;
      return;
    end
    if (trail_ws(c)) stage = PH_TRAIL;
    else stop_parse();
  endfunction

  function automatic void begin_body(logic [7:0] c, bit last);
    int r;
    r = radix_sel;
    if (c == CH_ZERO) begin
      zero_char = c;
      stage = PH_ZERO_HELD;
      return;
    end
    work_radix = (r < 0) ? -r : ((r == 0) ? int'(RAD_10) : r);
    stage = PH_DIGITS;
    take_digit(c, last);
  endfunction

  // Character after a leading zero: pick the radix, then replay or drop the prefix.
  function automatic void resolve_prefix(logic [7:0] c, bit last);
    int r;
    int det;
    bit letter;
    bit skip;
    r = radix_sel;
    letter = 1'b1;
    if (c == CH_LO_B || c == CH_UP_B) det = RAD_2;
    else if (c == CH_LO_O || c == CH_UP_O) det = RAD_8;
    else if (c == CH_LO_D || c == CH_UP_D) det = RAD_10;
    else if (c == CH_LO_X || c == CH_UP_X) det = RAD_16;
    else begin
      det = RAD_8;
      letter = 1'b0;
    end
    if (r <= 0) begin
      work_radix = det;
      skip = 1'b1;
    end else begin
      work_radix = r;
      skip = (r == det);
    end
    stage = PH_DIGITS;
    if (!skip) take_digit(zero_char, 1'b0);
    if (letter && skip) return;
    if (stage == PH_DIGITS) take_digit(c, last);
    else if (stage == PH_TRAIL && !trail_ws(c)) stop_parse();
  endfunction

  // Advance the parse by one byte; return 1 with the result on the last byte.
  function automatic bit parse_char(in_item_t it, output out_item_t res);
    int r;
    logic [7:0] c;
    bit last;
    r = radix_sel;
    c = it.char_code;
    last = it.last_char;
    res = '0;
    case (stage)
      PH_LEAD: begin
        if (r == RADIX_ONE || r == RADIX_NEG_ONE || r > RADIX_MAX || r < RADIX_MIN) begin
          stage = PH_INVALID;
        end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          if (c == CH_UNDER) stage = strict ? PH_INVALID : PH_DONE;
          else if (c == CH_MINUS) begin
            neg_seen = 1'b1;
            stage = PH_AFTER_SIGN;
          end else if (c == CH_PLUS) stage = PH_AFTER_SIGN;
          else begin_body(c, last);
        end
      end
      PH_AFTER_SIGN: begin_body(c, last);
      PH_ZERO_HELD:  resolve_prefix(c, last);
      PH_DIGITS:     take_digit(c, last);
      PH_TRAIL:      if (!trail_ws(c)) stop_parse();
      default: ;
    endcase
    if (!last) return 1'b0;
    if (stage == PH_INVALID || (cut_short && strict)) begin
      res.status = ST_INVALID;
    end else begin
      res.magnitude = acc;
      res.is_negative = neg_seen;
      res.status = ovf ? ST_OVERFLOW : ST_OK;
    end
    clear_string();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    bit bad;
    if (!rst_n) begin
      clear_string();
      radix_sel = RADIX_MODE_RST;
      strict = 1'b0;
      expected_q.delete();
      shown = 0;
      bad_cnt <= 0;
      checked_cnt <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RADIX_MODE) radix_sel = signed'(cfg_data);
        else if (cfg_index == REG_STRICT_MODE) strict = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        if (parse_char(in_data, want)) expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        bad = 1'b0;
        if (expected_q.size() == 0) begin
          bad = 1'b1;
          if (shown < SHOW_MAX)
            $display("[%0t] unexpected result: mag=%h neg=%0b status=%0d", $realtime,
                     got.magnitude, got.is_negative, got.status);
        end else begin
          want = expected_q.pop_front();
          bad = got.magnitude !== want.magnitude || got.is_negative !== want.is_negative ||
                got.status !== want.status;
          if (bad && shown < SHOW_MAX)
            $display({"[%0t] mismatch: expected mag=%h neg=%0b status=%0d, ",
                      "got mag=%h neg=%0b status=%0d"},
                     $realtime, want.magnitude, want.is_negative, want.status,
                     got.magnitude, got.is_negative, got.status);
        end
        if (bad) begin
          shown++;
          bad_cnt <= bad_cnt + 1;
        end
        checked_cnt <= checked_cnt + 1;
      end
      pending <= expected_q.size();
    end
  end

endmodule

FILE: bench/tb_radix_string_to_integer.sv
// Testbench top for radix_string_to_integer: drives numeral strings and register
// writes with random idling and gives the verdict. Depends on rsti_pkg,
// radix_parse_checker and the block itself.
`timescale 1ns / 1ps

module tb_radix_string_to_integer;
  import rsti_pkg::*;

  localparam int ITEM_GOAL     = 1450;
  localparam int STRINGS_PER_SETTING = 12;
  localparam int DRAIN_CYCLES  = 4;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int bad_cnt;
  int checked_cnt;
  int pending;

  int  cycle_cnt = 0;
  int  items_sent = 0;
  int  strings_sent = 0;
  int  settings_used = 0;
  int  radix_now = RADIX_MODE_RST;
  bit  quiet = 1'b0;
  int  hold_cnt = 0;
  logic [7:0] text_q[$];

  // Radix settings walked in order: detect, fixed, hint, and every out-of-range kind.
  int radix_plan[16] = '{0, 10, 16, 2, 8, 36, -36, -16, -2, 1, -1, 37, -37, 63, -64, -8};

  radix_string_to_integer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  radix_parse_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .bad_cnt     (bad_cnt),
    .checked_cnt (checked_cnt),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abort well past the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("** radix_string_to_integer: FAILED **");
      $finish;
    end
  end

  // Result side: after each taken result, drop ready at random and raise it again once
  // hold_cnt counts down (no stall while the current string is a quiet one).
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (out_ready && out_valid) begin
      n = quiet ? 0 : $urandom_range(0, 4);
      hold_cnt <= n;
      out_ready <= (n == 0);
    end else if (!out_ready) begin
      if (hold_cnt <= 1) out_ready <= 1'b1;
      else hold_cnt <= hold_cnt - 1;
    end
  end

  // Send one byte: idle for a random gap first, then hold valid until taken.
  task automatic send_byte(input logic [7:0] c, input bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= '{char_code: c, last_char: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic send_numeral();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  // Hold off the sender until every result is back, then let the pipe drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two.
  task automatic write_config(input int radix, input bit strict_on);
    cfg_index <= REG_RADIX_MODE;
    cfg_data <= CFG_DATA_W'(radix);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_STRICT_MODE;
    cfg_data <= CFG_DATA_W'(strict_on);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_now = radix;
    settings_used++;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] lead_blank();
    return ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] trail_blank();
    case ($urandom_range(0, 3))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // Build one numeral in text_q. Mostly well-formed (blanks, sign, prefix, digits
  // of the radix in force, single underscores, trailing blanks); some get a stray
  // byte, a leading or doubled underscore, or are plain noise.
  task automatic build_numeral();
    int kind;
    int base;
    int ndig;
    int v;
    int pfx;
    logic [7:0] ch;
    text_q.delete();
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(lead_blank());
    if (kind == 2) text_q.push_back(CH_UNDER);
    case ($urandom_range(0, 3))
      0: text_q.push_back(CH_MINUS);
      1: text_q.push_back(CH_PLUS);
      default: ;
    endcase
    base = (radix_now < 0) ? -radix_now : ((radix_now == 0) ? int'(RAD_10) : radix_now);
    if (base < 2 || base > 36) base = $urandom_range(2, 36);
    // Prefix: in detect and hint modes the digits follow the prefix's radix;
    // under a fixed radix a mismatching prefix gets replayed as digits.
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_ZERO);
      pfx = $urandom_range(0, 4);
      case (pfx)
        0: begin ch = CH_LO_B; v = RAD_2;  end
        1: begin ch = CH_LO_O; v = RAD_8;  end
        2: begin ch = CH_LO_D; v = RAD_10; end
        3: begin ch = CH_LO_X; v = RAD_16; end
        default: begin ch = CH_ZERO; v = RAD_8; end
      endcase
      if (pfx < 4) text_q.push_back($urandom_range(0, 1) ? ch : ch - (CH_LO_A - CH_UP_A));
      if (radix_now <= 0) base = v;
    end
    // Mostly short digit runs; now and then a long one that can overflow.
    ndig = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 8);
    for (int i = 0; i < ndig; i++) begin
      if (i != 0 && $urandom_range(0, 7) == 0) begin
        text_q.push_back(CH_UNDER);
        if ($urandom_range(0, 15) == 0) text_q.push_back(CH_UNDER);
      end
      v = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 35) : $urandom_range(0, base - 1);
      text_q.push_back(digit_char(v));
    end
    if ($urandom_range(0, 29) == 0) text_q.push_back(CH_UNDER);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) text_q.push_back(trail_blank());
      if ($urandom_range(0, 2) == 0) text_q.push_back(digit_char($urandom_range(0, 35)));
    end
    if (kind < 5) text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
    if (text_q.size() == 0) text_q.push_back(CH_SPACE);
  endtask

  initial begin
    int plan_idx;
    int left_in_setting;
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings (radix 10, lenient) first.
    send_text("\t-12");  // leading blank and minus sign
    send_text("_5");     // leading underscore, lenient -> zero
    send_text("9 x");    // garbage after trailing blank
    settle();
    write_config(0, 1'b1);
    send_text("0x1F");   // detected hex prefix
    send_text("07_7");   // bare zero means octal, single underscore
    send_text("1__2");   // doubled underscore stops, strict -> invalid
    send_text("_");      // leading underscore, strict -> invalid
    settle();
    write_config(16, 1'b0);
    send_text("0b1");    // prefix letter is a hex digit: replayed
    send_byte(8'hFF, 1'b1);
    strings_sent++;
    settle();
    write_config(RADIX_ONE, 1'b0);
    send_text("5");      // radix one is rejected

    // Random: walk the radix plan, then random settings.
    plan_idx = 0;
    left_in_setting = 0;
    while (items_sent < ITEM_GOAL) begin
      if (left_in_setting == 0) begin
        settle();
        if (plan_idx < 16) r = radix_plan[plan_idx];
        else if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 127) - 64;
        else r = $urandom_range(0, 72) - 36;
        write_config(r, (plan_idx < 2) ? plan_idx[0] : 1'($urandom_range(0, 1)));
        plan_idx++;
        left_in_setting = STRINGS_PER_SETTING;
      end
      quiet = ($urandom_range(0, 5) == 0);
      build_numeral();
      send_numeral();
      left_in_setting--;
    end

    quiet = 1'b0;
    settle();
    $display("Covered %0d strings, %0d bytes under %0d register settings;", strings_sent,
             items_sent, settings_used);
    $display("%0d results compared, %0d mismatches.", checked_cnt, bad_cnt);
    if (bad_cnt == 0 && pending == 0) begin
      $display("** radix_string_to_integer: PASSED **");
    end else begin
      $display("** radix_string_to_integer: FAILED **");
    end
    $finish;
  end

endmodule
